// ----- src/phsl_pkg.sv -----
// Package with the shared types, constants and helper functions of the pixel HSL adjust unit.
`timescale 1ns / 1ps
`default_nettype none
package phsl_pkg;

	// Number of register stages from input to output.
	localparam int NUM_STAGES = 10;

	// Configuration register indexes.
	localparam logic [1:0] REG_HUE_SET     = 2'd0;
	localparam logic [1:0] REG_SAT_SCALE   = 2'd1;
	localparam logic [1:0] REG_LIGHT_SCALE = 2'd2;

	localparam int HUE_W   = 10;
	localparam int SCALE_W = 11;
	localparam int CFG_W   = 11;

	// Hue constants in degrees.
	localparam logic [8:0] HUE_FULL   = 9'd360;
	localparam logic [8:0] HUE_THIRD  = 9'd120;
	localparam logic [8:0] HUE_2THIRD = 9'd240;
	localparam logic [8:0] HUE_SIXTH  = 9'd60;
	localparam logic [8:0] HUE_MOD    = 9'd361;

	// floor(x / 60) == (x * RECIP_60) >> RECIP_SHIFT for every x below 2**14.
	localparam logic [14:0] RECIP_60    = 15'd17477;
	localparam int          RECIP_SHIFT = 20;

	// Which channel holds the maximum; selects the hue sector offset.
	typedef enum logic [1:0] {
		BASE_R,
		BASE_G,
		BASE_B
	} hue_base_t;

	// One restoring division step: returns {quotient bit, next remainder}.
	function automatic logic [10:0] div_step(input logic [9:0] rem, input logic nbit,
		input logic [8:0] den);
		logic [9:0] sh;
		sh = {rem[8:0], nbit};
		if (sh >= {1'b0, den}) begin
			div_step = {1'b1, sh - {1'b0, den}};
		end else begin
			div_step = {1'b0, sh};
		end
	endfunction

endpackage
`default_nettype wire

// ----- src/phsl_pipe_ctrl.sv -----
// Valid and load-enable control of the pixel HSL adjust pipeline.
`timescale 1ns / 1ps
`default_nettype none
module phsl_pipe_ctrl
	import phsl_pkg::*;
#(
	parameter int STAGES = 10
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [STAGES-1:0]      stage_en,
	output logic [STAGES-1:0]      stage_vld
);

	logic [STAGES-1:0] vld_q;

	// A stage loads when it is empty or when the stage after it loads.
	always_comb begin
		stage_en[STAGES-1] = !vld_q[STAGES-1] || !out_stall;
		for (int k = STAGES - 2; k >= 0; k--) begin
			stage_en[k] = !vld_q[k] || stage_en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < STAGES; k++) begin
				if (stage_en[k]) begin
					vld_q[k] <= (k == 0) ? in_valid : vld_q[(k == 0) ? 0 : k - 1];
				end
			end
		end
	end

	assign in_stall  = !stage_en[0];
	assign out_valid = vld_q[STAGES-1];
	assign stage_vld = vld_q;

endmodule
`default_nettype wire

// ----- src/phsl_channel.sv -----
// Three-stage HSL to RGB conversion of one color channel.
`timescale 1ns / 1ps
`default_nettype none
module phsl_channel
	import phsl_pkg::*;
(
	input  wire logic       clk,
	input  wire logic [2:0] en,
	input  wire logic [8:0] t,
	input  wire logic [8:0] p,
	input  wire logic [8:0] q,
	input  wire logic       gray,
	input  wire logic [7:0] l,
	output logic [7:0]      chan
);

	logic [5:0]  k;
	logic [8:0]  diff;
	logic [14:0] x_s8;
	logic [8:0]  p_s8, p_s9;
	logic        gray_s8, gray_s9;
	logic [7:0]  l_s8, l_s9;
	logic [8:0]  quo_s9;
	logic [29:0] recip_prod;
	logic [9:0]  sum;
	logic [7:0]  chan_s10;

	// The ramp weight; the flat top uses weight 60 so that p + (q - p) gives q.
	always_comb begin
		diff = q - p;
		if (t < HUE_SIXTH) begin
			k = t[5:0];
		end else if (t < 9'd180) begin
			k = HUE_SIXTH[5:0];
		end else if (t < HUE_2THIRD) begin
			k = 6'(HUE_2THIRD - t);
		end else begin
			k = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			x_s8    <= 15'({6'b0, diff} * {9'b0, k});
			p_s8    <= p;
			gray_s8 <= gray;
			l_s8    <= l;
		end
	end

	assign recip_prod = {15'b0, x_s8} * {15'b0, RECIP_60};

	always_ff @(posedge clk) begin
		if (en[1]) begin
			quo_s9  <= recip_prod[RECIP_SHIFT+8:RECIP_SHIFT];
			p_s9    <= p_s8;
			gray_s9 <= gray_s8;
			l_s9    <= l_s8;
		end
	end

	assign sum = {1'b0, p_s9} + {1'b0, quo_s9};

	always_ff @(posedge clk) begin
		if (en[2]) begin
			if (gray_s9) begin
				chan_s10 <= l_s9;
			end else if (sum > 10'd255) begin
				chan_s10 <= 8'hff;
			end else begin
				chan_s10 <= sum[7:0];
			end
		end
	end

	assign chan = chan_s10;

endmodule
`default_nettype wire

// ----- src/pixel_hsl_adjust_unit.sv -----
// Top level of the pixel HSL adjust unit: RGB to HSL, adjust, and back to RGB.
`timescale 1ns / 1ps
`default_nettype none
// The unit takes one pixel transaction per clock unless in_stall is raised,
// and returns one adjusted pixel per transaction, in order. It has ten
// register stages: color analysis, three restoring-division stages that form
// saturation (three quotient bits per stage) and hue (three bits per stage over
// the first two), the hue and scaling stage, the clamp and lightness product
// stage, the q and p stage, and three stages per output channel for the ramp
// multiply, the divide by sixty and the final clamp. Every stage holds a valid bit, and a
// stage loads whenever it is empty or its successor loads, so empty slots close up while
// the output waits and input transactions are still taken. Alpha and the last-pixel flag
// travel with the pixel unchanged. Configuration registers must be written only while the
// pipeline is empty; a negative value of a register keeps the pixel's own component.
module pixel_hsl_adjust_unit
	import phsl_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [1:0]           wr_index,
	input  wire logic [CFG_W-1:0]     wr_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [31:0]          pixel_in,
	input  wire logic                 last_pixel,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [31:0]               pixel_out,
	output logic                      last_pixel_out
);

	logic [NUM_STAGES-1:0] stage_en;
	logic [NUM_STAGES-1:0] stage_vld;

	// Configuration registers.
	logic [HUE_W-1:0]   hue_set_q;
	logic [SCALE_W-1:0] sat_scale_q;
	logic [SCALE_W-1:0] light_scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_set_q     <= '1;
			sat_scale_q   <= '1;
			light_scale_q <= '1;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_HUE_SET:     hue_set_q     <= wr_data[HUE_W-1:0];
				REG_SAT_SCALE:   sat_scale_q   <= wr_data[SCALE_W-1:0];
				REG_LIGHT_SCALE: light_scale_q <= wr_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	phsl_pipe_ctrl #(
		.STAGES(NUM_STAGES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stage_en  (stage_en),
		.stage_vld (stage_vld)
	);

	// Alpha and the last flag ride along every stage.
	logic [8:0] side_s [NUM_STAGES];

	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_STAGES; k++) begin
			if (stage_en[k]) begin
				side_s[k] <= (k == 0) ? {last_pixel, pixel_in[31:24]}
				                      : side_s[(k == 0) ? 0 : k - 1];
			end
		end
	end

	// Stage 1: find max, min, lightness, and set up both divisions.
	logic [7:0]  r_in, g_in, b_in, mx, mn, d, hd_a, hd_b;
	logic [8:0]  sum, den;
	logic [7:0]  l_in;
	hue_base_t   base_in;
	logic        neg_in;
	logic [7:0]  mag_in;

	always_comb begin
		r_in = pixel_in[7:0];
		g_in = pixel_in[15:8];
		b_in = pixel_in[23:16];
		mx   = (r_in > g_in) ? r_in : g_in;
		mx   = (mx > b_in) ? mx : b_in;
		mn   = (r_in < g_in) ? r_in : g_in;
		mn   = (mn < b_in) ? mn : b_in;
		d    = mx - mn;
		sum  = {1'b0, mx} + {1'b0, mn};
		l_in = sum[8:1];
		den  = (l_in <= 8'd128) ? sum : 9'(10'd512 - {1'b0, sum});
		// Red wins ties, then green, matching the sector order of the hue formula.
		if (mx == r_in) begin
			base_in = BASE_R;
			hd_a    = g_in;
			hd_b    = b_in;
		end else if (mx == g_in) begin
			base_in = BASE_G;
			hd_a    = b_in;
			hd_b    = r_in;
		end else begin
			base_in = BASE_B;
			hd_a    = r_in;
			hd_b    = g_in;
		end
		neg_in = hd_a < hd_b;
		mag_in = neg_in ? (hd_b - hd_a) : (hd_a - hd_b);
	end

	logic [8:0]  sden_s1;
	logic [7:0]  d_s1, l_s1;
	logic [13:0] hnum_s1;
	logic        neg_s1, gray_s1, dz_s1;
	hue_base_t   base_s1;

	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			sden_s1 <= den;
			d_s1    <= d;
			l_s1    <= l_in;
			hnum_s1 <= 14'({6'b0, mag_in} * 14'd60);
			neg_s1  <= neg_in;
			base_s1 <= base_in;
			gray_s1 <= (l_in == 8'd0) || (d == 8'd0);
			dz_s1   <= d == 8'd0;
		end
	end

	// Stages 2 to 4: restoring division. Saturation is (d << 8) / den with a nine-bit
	// quotient; the starting remainder d >> 1 is already below den. Hue magnitude is
	// 60 * |diff| / d with a six-bit quotient, starting from the numerator's top bits.
	logic [9:0]  srem_s2, srem_s3;
	logic [8:0]  sq_s2, sq_s3, sq_s4;
	logic [8:0]  snum_s2, snum_s3;
	logic [9:0]  hrem_s2;
	logic [5:0]  hq_s2, hq_s3, hq_s4;
	logic [5:0]  hnum_s2;
	logic [8:0]  sden_s2, sden_s3;
	logic [7:0]  d_s2;
	logic [7:0]  l_s2, l_s3, l_s4;
	logic        neg_s2, neg_s3, neg_s4;
	logic        gray_s2, gray_s3, gray_s4;
	logic        dz_s2, dz_s3, dz_s4;
	hue_base_t   base_s2, base_s3, base_s4;

	logic [9:0]  srem_n2, srem_n3, srem_n4, hrem_n2, hrem_n3;
	logic [8:0]  sq_n2, sq_n3, sq_n4;
	logic [5:0]  hq_n2, hq_n3;
	logic [10:0] st_n2, st_n3, st_n4;
	logic [8:0]  snum1;

	always_comb begin
		snum1   = {d_s1[0], 8'b0};
		srem_n2 = {3'b0, d_s1[7:1]};
		sq_n2   = '0;
		hrem_n2 = {2'b0, hnum_s1[13:6]};
		hq_n2   = '0;
		for (int i = 0; i < 3; i++) begin
			st_n2   = div_step(srem_n2, snum1[8-i], sden_s1);
			srem_n2 = st_n2[9:0];
			sq_n2   = {sq_n2[7:0], st_n2[10]};
			st_n2   = div_step(hrem_n2, hnum_s1[5-i], {1'b0, d_s1});
			hrem_n2 = st_n2[9:0];
			hq_n2   = {hq_n2[4:0], st_n2[10]};
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			srem_s2 <= srem_n2;
			sq_s2   <= sq_n2;
			snum_s2 <= snum1;
			sden_s2 <= sden_s1;
			hrem_s2 <= hrem_n2;
			hq_s2   <= hq_n2;
			hnum_s2 <= hnum_s1[5:0];
			d_s2    <= d_s1;
			l_s2    <= l_s1;
			neg_s2  <= neg_s1;
			base_s2 <= base_s1;
			gray_s2 <= gray_s1;
			dz_s2   <= dz_s1;
		end
	end

	always_comb begin
		srem_n3 = srem_s2;
		sq_n3   = sq_s2;
		hrem_n3 = hrem_s2;
		hq_n3   = hq_s2;
		for (int i = 0; i < 3; i++) begin
			st_n3   = div_step(srem_n3, snum_s2[5-i], sden_s2);
			srem_n3 = st_n3[9:0];
			sq_n3   = {sq_n3[7:0], st_n3[10]};
			st_n3   = div_step(hrem_n3, hnum_s2[2-i], {1'b0, d_s2});
			hrem_n3 = st_n3[9:0];
			hq_n3   = {hq_n3[4:0], st_n3[10]};
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			srem_s3 <= srem_n3;
			sq_s3   <= sq_n3;
			snum_s3 <= snum_s2;
			sden_s3 <= sden_s2;
			hq_s3   <= hq_n3;
			l_s3    <= l_s2;
			neg_s3  <= neg_s2;
			base_s3 <= base_s2;
			gray_s3 <= gray_s2;
			dz_s3   <= dz_s2;
		end
	end

	always_comb begin
		srem_n4 = srem_s3;
		sq_n4   = sq_s3;
		for (int i = 0; i < 3; i++) begin
			st_n4   = div_step(srem_n4, snum_s3[2-i], sden_s3);
			srem_n4 = st_n4[9:0];
			sq_n4   = {sq_n4[7:0], st_n4[10]};
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[3]) begin
			sq_s4   <= sq_n4;
			hq_s4   <= hq_s3;
			l_s4    <= l_s3;
			neg_s4  <= neg_s3;
			base_s4 <= base_s3;
			gray_s4 <= gray_s3;
			dz_s4   <= dz_s3;
		end
	end

	// Stage 5: finish the hue, apply the hue override and scale s and l.
	logic [8:0]  base_val, h_own, h_cfg, h_n5;
	logic [7:0]  s_raw;
	logic [17:0] s_prod, l_prod;
	logic [9:0]  s_n5, l_n5;

	always_comb begin
		case (base_s4)
			BASE_G:  base_val = HUE_THIRD;
			BASE_B:  base_val = HUE_2THIRD;
			default: base_val = '0;
		endcase
		if (dz_s4) begin
			h_own = '0;
		end else if (neg_s4) begin
			// A negative red-sector hue wraps around the circle.
			if (base_val == 9'd0 && hq_s4 != 6'd0) begin
				h_own = HUE_FULL - {3'b0, hq_s4};
			end else begin
				h_own = base_val - {3'b0, hq_s4};
			end
		end else begin
			h_own = base_val + {3'b0, hq_s4};
		end
		h_cfg = (hue_set_q[8:0] >= HUE_MOD) ? (hue_set_q[8:0] - HUE_MOD) : hue_set_q[8:0];
		h_n5  = hue_set_q[HUE_W-1] ? h_own : h_cfg;

		if (gray_s4) begin
			s_raw = '0;
		end else if (sq_s4 > 9'd255) begin
			s_raw = 8'hff;
		end else begin
			s_raw = sq_s4[7:0];
		end
		s_prod = {10'b0, s_raw} * {8'b0, sat_scale_q[9:0]};
		l_prod = {10'b0, l_s4} * {8'b0, light_scale_q[9:0]};
		s_n5   = sat_scale_q[SCALE_W-1] ? {2'b0, s_raw} : s_prod[17:8];
		l_n5   = light_scale_q[SCALE_W-1] ? {2'b0, l_s4} : l_prod[17:8];
	end

	logic [8:0] h_s5, h_s6, h_s7;
	logic [9:0] s_s5, l_s5;

	always_ff @(posedge clk) begin
		if (stage_en[4]) begin
			h_s5 <= h_n5;
			s_s5 <= s_n5;
			l_s5 <= l_n5;
		end
	end

	// Stage 6: clamp the scaled values and form l * s.
	logic [7:0]  s_c6, l_c6;
	logic [15:0] ls_prod;
	logic [7:0]  s_s6, l_s6, ls_s6;

	always_comb begin
		s_c6    = (s_s5 > 10'd255) ? 8'hff : s_s5[7:0];
		l_c6    = (l_s5 > 10'd255) ? 8'hff : l_s5[7:0];
		ls_prod = {8'b0, l_c6} * {8'b0, s_c6};
	end

	always_ff @(posedge clk) begin
		if (stage_en[5]) begin
			s_s6  <= s_c6;
			l_s6  <= l_c6;
			ls_s6 <= ls_prod[15:8];
			h_s6  <= h_s5;
		end
	end

	// Stage 7: q, p and the three wrapped channel hues.
	logic [8:0] q_n7, p_n7, tr_n7, tb_n7;
	logic [9:0] tr_sum;
	logic [8:0] q_s7, p_s7, tr_s7, tg_s7, tb_s7;
	logic [7:0] l_s7;
	logic       gray_s7;

	always_comb begin
		if (l_s6 < 8'd128) begin
			q_n7 = {1'b0, l_s6} + {1'b0, ls_s6};
		end else begin
			q_n7 = 9'({1'b0, l_s6} + {1'b0, s_s6} - {1'b0, ls_s6});
		end
		p_n7   = {l_s6, 1'b0} - q_n7;
		tr_sum = {1'b0, h_s6} + {1'b0, HUE_THIRD};
		tr_n7  = (tr_sum > {1'b0, HUE_FULL}) ? 9'(tr_sum - {1'b0, HUE_FULL}) : tr_sum[8:0];
		tb_n7  = (h_s6 < HUE_THIRD) ? (h_s6 + HUE_2THIRD) : (h_s6 - HUE_THIRD);
	end

	always_ff @(posedge clk) begin
		if (stage_en[6]) begin
			q_s7    <= q_n7;
			p_s7    <= p_n7;
			tr_s7   <= tr_n7;
			tg_s7   <= h_s6;
			tb_s7   <= tb_n7;
			l_s7    <= l_s6;
			gray_s7 <= s_s6 == 8'd0;
		end
	end

	// Stages 8 to 10: one converter per channel.
	logic [7:0] r_out, g_out, b_out;

	phsl_channel u_red (
		.clk  (clk),
		.en   (stage_en[9:7]),
		.t    (tr_s7),
		.p    (p_s7),
		.q    (q_s7),
		.gray (gray_s7),
		.l    (l_s7),
		.chan (r_out)
	);

	phsl_channel u_green (
		.clk  (clk),
		.en   (stage_en[9:7]),
		.t    (tg_s7),
		.p    (p_s7),
		.q    (q_s7),
		.gray (gray_s7),
		.l    (l_s7),
		.chan (g_out)
	);

	phsl_channel u_blue (
		.clk  (clk),
		.en   (stage_en[9:7]),
		.t    (tb_s7),
		.p    (p_s7),
		.q    (q_s7),
		.gray (gray_s7),
		.l    (l_s7),
		.chan (b_out)
	);

	assign pixel_out      = {side_s[NUM_STAGES-1][7:0], b_out, g_out, r_out};
	assign last_pixel_out = side_s[NUM_STAGES-1][8];

`ifndef NO_ASSERTIONS
	// An accepted transaction always lands in the first stage.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> stage_vld[0])
		else $error("accepted transaction lost at stage 1");

	// A stage only holds its contents when it is full.
	a_hold_full: assert property (@(posedge clk) disable iff (!arst_n)
		((~stage_vld & ~stage_en) == '0))
		else $error("empty stage held");

	// The hue leaving stage 5 stays on the circle.
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		stage_vld[4] |-> (h_s5 <= HUE_FULL))
		else $error("hue out of range");

	// q never falls below p for a colored pixel.
	a_q_ge_p: assert property (@(posedge clk) disable iff (!arst_n)
		(stage_vld[6] && !gray_s7) |-> (q_s7 >= p_s7))
		else $error("q below p");
`endif

endmodule
`default_nettype wire
